// ===== design/dcdb_pkg.sv =====
// Shared constants, types and arithmetic helpers for the dual conic decomposition block.
package dcdb_pkg;

   localparam int MW = 52;
   localparam int HW = MW / 2;
   localparam int RW = 2 * MW;
   localparam int SQ_STEPS = RW / 2;
   localparam int NX_SHIFT = 14;
   localparam int AX_SHIFT = 15;
   localparam int DIV_Q = 70;
   localparam int DIV_N = RW + 1 + NX_SHIFT;
   localparam int CORD_STEPS = 16;
   localparam int CW = 54;
   localparam int ZW = 20;
   localparam int OW = 15;
   localparam int HALF_PI_Q13 = 12868;
   localparam int PI_Q16 = 205887;
   localparam int ROUND_Q16 = 32768;
   localparam int ANGLE_ROUND = 8;
   localparam int ANGLE_SHIFT = 4;
   localparam int LATENCY = 4 + (CORD_STEPS + 1) + 1 + 3 + SQ_STEPS + 4 + DIV_Q + SQ_STEPS + 1;

   localparam logic signed [ZW-1:0] ATAN_TAB [CORD_STEPS] = '{
      20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047, 20'sd1024,
      20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16, 20'sd8, 20'sd4, 20'sd2
   };

   localparam logic signed [55:0] S32_MAX = 56'sd2147483647;
   localparam logic signed [55:0] S32_MIN = -56'sd2147483648;

   typedef struct packed {
      logic signed [MW-1:0] d;
      logic signed [MW-1:0] q;
      logic signed [MW-1:0] s;
      logic signed [31:0]   xz;
      logic signed [31:0]   yz;
   } geo_type;

   typedef struct packed {
      geo_type              geo;
      logic signed [OW-1:0] ori;
   } band_type;

   typedef struct packed {
      logic signed [31:0]   xz;
      logic signed [31:0]   yz;
      logic signed [OW-1:0] ori;
      logic                 hz;
   } tail_type;

   typedef struct packed {
      logic [RW-1:0] ra0;
      logic [RW-1:0] ra1;
      tail_type      tail;
   } mid_type;

   typedef struct packed {
      logic [MW-1:0] ll;
      logic [MW-1:0] lh;
      logic [MW-1:0] hl;
      logic [MW-1:0] hh;
   } part_type;

   // Four half-width partial products of an unsigned product.
   function automatic part_type mul_split(input logic [MW-1:0] a, input logic [MW-1:0] b);
      part_type r;
      r.ll = MW'(a[HW-1:0]) * MW'(b[HW-1:0]);
      r.lh = MW'(a[HW-1:0]) * MW'(b[MW-1:HW]);
      r.hl = MW'(a[MW-1:HW]) * MW'(b[HW-1:0]);
      r.hh = MW'(a[MW-1:HW]) * MW'(b[MW-1:HW]);
      return r;
   endfunction

   function automatic logic [RW-1:0] mul_join(input part_type p);
      logic [RW-1:0] r;
      r = (RW'(p.hh) << MW) + (RW'(p.lh) << HW) + (RW'(p.hl) << HW) + RW'(p.ll);
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < S32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

endpackage

// ===== design/dcdb_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
module dcdb_sqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [dcdb_pkg::RW-1:0]  in_rad,
   output logic                     out_valid,
   output logic [dcdb_pkg::MW-1:0]  out_root
);
   import dcdb_pkg::*;

   logic [RW-1:0] rad_ff  [SQ_STEPS];
   logic [RW-1:0] rad_in  [SQ_STEPS];
   logic [MW+1:0] rem_ff  [SQ_STEPS];
   logic [MW+1:0] rem_in  [SQ_STEPS];
   logic [MW-1:0] root_ff [SQ_STEPS];
   logic [MW-1:0] root_in [SQ_STEPS];
   logic          valid_ff [SQ_STEPS];

   always_comb begin
      logic [RW-1:0] rad_src;
      logic [MW+1:0] rem_src;
      logic [MW+1:0] rem_cat;
      logic [MW+1:0] trial;
      logic [MW-1:0] root_src;
      for (int i = 0; i < SQ_STEPS; i++) begin
         if (i == 0) begin
            rad_src  = in_rad;
            rem_src  = '0;
            root_src = '0;
         end else begin
            rad_src  = rad_ff[i-1];
            rem_src  = rem_ff[i-1];
            root_src = root_ff[i-1];
         end
         rem_cat   = {rem_src[MW-1:0], rad_src[RW-1:RW-2]};
         trial     = {root_src, 2'b01};
         rad_in[i] = rad_src << 2;
         if (rem_cat >= trial) begin
            rem_in[i]  = rem_cat - trial;
            root_in[i] = {root_src[MW-2:0], 1'b1};
         end else begin
            rem_in[i]  = rem_cat;
            root_in[i] = {root_src[MW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SQ_STEPS; i++) begin
         rad_ff[i]  <= rad_in[i];
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQ_STEPS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < SQ_STEPS; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[SQ_STEPS-1];
   assign out_root  = root_ff[SQ_STEPS-1];

endmodule

// ===== design/dcdb_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module dcdb_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [dcdb_pkg::DIV_N-1:0] in_num,
   input  logic [dcdb_pkg::MW-1:0]    in_den,
   output logic                       out_valid,
   output logic [dcdb_pkg::DIV_Q-1:0] out_quo
);
   import dcdb_pkg::*;

   logic [DIV_Q-1:0] num_ff [DIV_Q];
   logic [DIV_Q-1:0] num_in [DIV_Q];
   logic [MW-1:0]    rem_ff [DIV_Q];
   logic [MW-1:0]    rem_in [DIV_Q];
   logic [MW-1:0]    den_ff [DIV_Q];
   logic [MW-1:0]    den_in [DIV_Q];
   logic             valid_ff [DIV_Q];

   // The upper dividend bits are already below the divisor, so only the low bits make quotient.
   always_comb begin
      logic [DIV_Q-1:0] num_src;
      logic [MW-1:0]    rem_src;
      logic [MW-1:0]    den_src;
      logic [MW:0]      rem_cat;
      logic [MW:0]      den_cat;
      logic             ge;
      for (int i = 0; i < DIV_Q; i++) begin
         if (i == 0) begin
            num_src = in_num[DIV_Q-1:0];
            rem_src = MW'(in_num[DIV_N-1:DIV_Q]);
            den_src = in_den;
         end else begin
            num_src = num_ff[i-1];
            rem_src = rem_ff[i-1];
            den_src = den_ff[i-1];
         end
         rem_cat   = {rem_src, num_src[DIV_Q-1]};
         den_cat   = {1'b0, den_src};
         ge        = rem_cat >= den_cat;
         rem_in[i] = ge ? MW'(rem_cat - den_cat) : MW'(rem_cat);
         num_in[i] = {num_src[DIV_Q-2:0], ge};
         den_in[i] = den_src;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_Q; i++) begin
         num_ff[i] <= num_in[i];
         rem_ff[i] <= rem_in[i];
         den_ff[i] <= den_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_Q; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DIV_Q; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[DIV_Q-1];
   assign out_quo   = num_ff[DIV_Q-1];

endmodule

// ===== design/dual_conic_decompose_bbox.sv =====
// Top level of the dual conic ellipse decomposition and bounding box pipeline.
//
// A request beat is taken at every rising edge with start high and busy low. busy is
// held low, so a new conic can enter in every cycle and the block runs at one item per
// clock. Each conic yields exactly one result beat, shown for one cycle with rsp_strobe
// high and taken at the edge that ends that cycle.
// Every item passes through the same chain of stages, so results leave in request order.
// The depth is set by the chain of one-bit-per-stage units: a 17-stage angle rotator, a
// 52-stage square root for the eigenvalue spread, a 70-stage divider for the box extents
// and a final 52-stage square root, with multiply and add stages between them.
// Reset clears every valid bit, so items in flight are dropped and no beat follows
// until a new request. There is no configuration and no state between items.
// The receiver cannot hold results off, and the pipeline never needs to stall.
module dual_conic_decompose_bbox (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [47:0]              req_conic_xx,
   input  logic signed [47:0]              req_conic_xy,
   input  logic signed [47:0]              req_conic_yy,
   input  logic signed [31:0]              req_conic_xz,
   input  logic signed [31:0]              req_conic_yz,
   output logic                            rsp_strobe,
   output logic signed [31:0]              rsp_center_x,
   output logic signed [31:0]              rsp_center_y,
   output logic [31:0]                     rsp_axis_first,
   output logic [31:0]                     rsp_axis_second,
   output logic signed [dcdb_pkg::OW-1:0]  rsp_orientation,
   output logic signed [31:0]              rsp_box_left,
   output logic signed [31:0]              rsp_box_top,
   output logic signed [31:0]              rsp_box_right,
   output logic signed [31:0]              rsp_box_bottom
);
   import dcdb_pkg::*;

   // Stage 1: request beat.
   logic                 s1_v_ff;
   logic signed [47:0]   s1_xx_ff, s1_xy_ff, s1_yy_ff;
   logic signed [31:0]   s1_xz_ff, s1_yz_ff;
   // Stage 2: centre products.
   logic                 s2_v_ff;
   logic signed [47:0]   s2_xx_ff, s2_xy_ff, s2_yy_ff;
   logic signed [31:0]   s2_xz_ff, s2_yz_ff;
   logic signed [63:0]   s2_pxx_ff, s2_pyy_ff, s2_pxy_ff;
   // Stage 3: centred block.
   logic                 s3_v_ff;
   logic signed [MW-1:0] s3_mxx_ff, s3_myy_ff, s3_mxy_ff;
   logic signed [MW-1:0] s3_mxx_in, s3_myy_in, s3_mxy_in;
   logic signed [31:0]   s3_xz_ff, s3_yz_ff;
   // Stage 4: difference, off-diagonal and trace.
   logic                 s4_v_ff;
   geo_type              s4_geo_ff;
   // Angle rotator.
   logic                 cor_v_ff   [CORD_STEPS+1];
   geo_type              cor_geo_ff [CORD_STEPS+1];
   logic signed [CW-1:0] cor_x_ff   [CORD_STEPS+1];
   logic signed [CW-1:0] cor_y_ff   [CORD_STEPS+1];
   logic signed [ZW-1:0] cor_z_ff   [CORD_STEPS+1];
   logic signed [CW-1:0] cor_x_in   [CORD_STEPS+1];
   logic signed [CW-1:0] cor_y_in   [CORD_STEPS+1];
   logic signed [ZW-1:0] cor_z_in   [CORD_STEPS+1];
   // Orientation and magnitudes.
   logic                 o_v_ff;
   band_type             o_band_ff;
   logic signed [OW-1:0] o_ori_in;
   logic [MW-1:0]        o_ud_ff, o_uq_ff;
   // Squares of the spread.
   logic                 m1_v_ff, m2_v_ff, m3_v_ff;
   band_type             m1_band_ff, m2_band_ff, m3_band_ff;
   part_type             m1_pd_ff, m1_pq_ff;
   logic [RW-1:0]        m2_sd_ff, m2_sq_ff, m3_rad_ff;
   // Spread root and its side band.
   logic                 h_v;
   logic [MW-1:0]        h_root;
   band_type             hs_ff [SQ_STEPS];
   // Extent numerators.
   logic                 e1_v_ff, e2_v_ff, e3_v_ff, e4_v_ff;
   logic signed [MW-1:0] e1_sh_in, e1_sk_in;
   logic [MW-1:0]        e1_g_ff, e1_k_ff, e1_hm_ff, e1_hp_ff, e1_h_ff;
   logic [MW-1:0]        e2_g_ff, e2_k_ff, e2_h_ff, e3_g_ff, e3_k_ff, e3_h_ff, e4_h_ff;
   tail_type             e1_tail_ff, e2_tail_ff, e3_tail_ff;
   part_type             e2_p0_ff, e2_p1_ff, e2_p2_ff, e2_p3_ff;
   logic [RW-1:0]        e3_gm_ff, e3_kp_ff, e3_gp_ff, e3_km_ff;
   logic [DIV_N-1:0]     e4_nx_ff, e4_ny_ff;
   mid_type              e4_mid_ff;
   // Division and final roots.
   logic                 qx_v, qy_v;
   logic [DIV_Q-1:0]     qx, qy;
   mid_type              dl_ff [DIV_Q];
   tail_type             fs_ff [SQ_STEPS];
   logic                 rx_v, ry_v, r0_v, r1_v;
   logic [MW-1:0]        rx, ry, r0, r1;
   logic                 f_v;
   tail_type             f_tail;
   logic [MW-1:0]        f_xm, f_ym;
   logic signed [55:0]   f_cx, f_cy, f_xm_w, f_ym_w;
   // Result beat.
   logic                 rsp_strobe_ff;
   logic signed [31:0]   rsp_center_x_ff, rsp_center_y_ff;
   logic [31:0]          rsp_axis_first_ff, rsp_axis_second_ff;
   logic signed [OW-1:0] rsp_orientation_ff;
   logic signed [31:0]   rsp_box_left_ff, rsp_box_top_ff, rsp_box_right_ff, rsp_box_bottom_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
         e1_v_ff <= 1'b0;
         e2_v_ff <= 1'b0;
         e3_v_ff <= 1'b0;
         e4_v_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i <= CORD_STEPS; i++) begin
            cor_v_ff[i] <= 1'b0;
         end
      end else begin
         s1_v_ff <= start && !busy;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         cor_v_ff[0] <= s4_v_ff;
         for (int i = 1; i <= CORD_STEPS; i++) begin
            cor_v_ff[i] <= cor_v_ff[i-1];
         end
         o_v_ff  <= cor_v_ff[CORD_STEPS];
         m1_v_ff <= o_v_ff;
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff;
         e1_v_ff <= h_v;
         e2_v_ff <= e1_v_ff;
         e3_v_ff <= e2_v_ff;
         e4_v_ff <= e3_v_ff;
         rsp_strobe_ff <= f_v;
      end
   end

   always_ff @(posedge clock) begin
      s1_xx_ff <= req_conic_xx;
      s1_xy_ff <= req_conic_xy;
      s1_yy_ff <= req_conic_yy;
      s1_xz_ff <= req_conic_xz;
      s1_yz_ff <= req_conic_yz;

      s2_xx_ff  <= s1_xx_ff;
      s2_xy_ff  <= s1_xy_ff;
      s2_yy_ff  <= s1_yy_ff;
      s2_xz_ff  <= s1_xz_ff;
      s2_yz_ff  <= s1_yz_ff;
      s2_pxx_ff <= 64'(s1_xz_ff) * 64'(s1_xz_ff);
      s2_pyy_ff <= 64'(s1_yz_ff) * 64'(s1_yz_ff);
      s2_pxy_ff <= 64'(s1_xz_ff) * 64'(s1_yz_ff);

      s3_mxx_ff <= s3_mxx_in;
      s3_myy_ff <= s3_myy_in;
      s3_mxy_ff <= s3_mxy_in;
      s3_xz_ff  <= s2_xz_ff;
      s3_yz_ff  <= s2_yz_ff;

      s4_geo_ff.d  <= s3_mxx_ff - s3_myy_ff;
      s4_geo_ff.q  <= s3_mxy_ff <<< 1;
      s4_geo_ff.s  <= s3_mxx_ff + s3_myy_ff;
      s4_geo_ff.xz <= s3_xz_ff;
      s4_geo_ff.yz <= s3_yz_ff;
   end

   // Products are rounded to Q.16 by adding one half and flooring.
   always_comb begin
      s3_mxx_in = MW'(s2_xx_ff) + MW'((s2_pxx_ff + 64'(ROUND_Q16)) >>> 16);
      s3_myy_in = MW'(s2_yy_ff) + MW'((s2_pyy_ff + 64'(ROUND_Q16)) >>> 16);
      s3_mxy_in = MW'(s2_xy_ff) + MW'((s2_pxy_ff + 64'(ROUND_Q16)) >>> 16);
   end

   // Vectoring rotation of (d, q): a half-plane fold, then one micro-rotation per stage.
   always_comb begin
      logic signed [CW-1:0] x_src;
      logic signed [CW-1:0] y_src;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      x_src = CW'(s4_geo_ff.d);
      y_src = CW'(s4_geo_ff.q);
      if (x_src < 0) begin
         cor_x_in[0] = -x_src;
         cor_y_in[0] = -y_src;
         cor_z_in[0] = (y_src >= 0) ? ZW'(PI_Q16) : -ZW'(PI_Q16);
      end else begin
         cor_x_in[0] = x_src;
         cor_y_in[0] = y_src;
         cor_z_in[0] = '0;
      end
      for (int i = 1; i <= CORD_STEPS; i++) begin
         dx = cor_y_ff[i-1] >>> (i - 1);
         dy = cor_x_ff[i-1] >>> (i - 1);
         if (cor_y_ff[i-1] >= 0) begin
            cor_x_in[i] = cor_x_ff[i-1] + dx;
            cor_y_in[i] = cor_y_ff[i-1] - dy;
            cor_z_in[i] = cor_z_ff[i-1] + ATAN_TAB[i-1];
         end else begin
            cor_x_in[i] = cor_x_ff[i-1] - dx;
            cor_y_in[i] = cor_y_ff[i-1] + dy;
            cor_z_in[i] = cor_z_ff[i-1] - ATAN_TAB[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      cor_geo_ff[0] <= s4_geo_ff;
      for (int i = 1; i <= CORD_STEPS; i++) begin
         cor_geo_ff[i] <= cor_geo_ff[i-1];
      end
      for (int i = 0; i <= CORD_STEPS; i++) begin
         cor_x_ff[i] <= cor_x_in[i];
         cor_y_ff[i] <= cor_y_in[i];
         cor_z_ff[i] <= cor_z_in[i];
      end
   end

   // Angle of the first axis: halve, clamp, then turn a quarter turn toward zero.
   always_comb begin
      logic signed [ZW-1:0] t;
      geo_type              g;
      g = cor_geo_ff[CORD_STEPS];
      t = (cor_z_ff[CORD_STEPS] + ZW'(ANGLE_ROUND)) >>> ANGLE_SHIFT;
      if (t > ZW'(HALF_PI_Q13)) begin
         t = ZW'(HALF_PI_Q13);
      end
      if (t < -ZW'(HALF_PI_Q13)) begin
         t = -ZW'(HALF_PI_Q13);
      end
      if (g.q == 0) begin
         o_ori_in = (g.d > 0) ? OW'(HALF_PI_Q13) : '0;
      end else if (t > 0) begin
         o_ori_in = OW'(t - ZW'(HALF_PI_Q13));
      end else begin
         o_ori_in = OW'(t + ZW'(HALF_PI_Q13));
      end
   end

   always_ff @(posedge clock) begin
      o_band_ff.geo <= cor_geo_ff[CORD_STEPS];
      o_band_ff.ori <= o_ori_in;
      o_ud_ff <= (cor_geo_ff[CORD_STEPS].d < 0) ? MW'(-cor_geo_ff[CORD_STEPS].d)
                                                : MW'(cor_geo_ff[CORD_STEPS].d);
      o_uq_ff <= (cor_geo_ff[CORD_STEPS].q < 0) ? MW'(-cor_geo_ff[CORD_STEPS].q)
                                                : MW'(cor_geo_ff[CORD_STEPS].q);

      m1_band_ff <= o_band_ff;
      m1_pd_ff   <= mul_split(o_ud_ff, o_ud_ff);
      m1_pq_ff   <= mul_split(o_uq_ff, o_uq_ff);
      m2_band_ff <= m1_band_ff;
      m2_sd_ff   <= mul_join(m1_pd_ff);
      m2_sq_ff   <= mul_join(m1_pq_ff);
      m3_band_ff <= m2_band_ff;
      m3_rad_ff  <= m2_sd_ff + m2_sq_ff;

      hs_ff[0] <= m3_band_ff;
      for (int i = 1; i < SQ_STEPS; i++) begin
         hs_ff[i] <= hs_ff[i-1];
      end
   end

   dcdb_sqrt u_spread_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m3_v_ff),
      .in_rad    (m3_rad_ff),
      .out_valid (h_v),
      .out_root  (h_root)
   );

   // Twice the eigenvalues are s - h and s + h.
   always_comb begin
      e1_sh_in = hs_ff[SQ_STEPS-1].geo.s - $signed(h_root);
      e1_sk_in = hs_ff[SQ_STEPS-1].geo.s + $signed(h_root);
   end

   always_ff @(posedge clock) begin
      e1_g_ff  <= (e1_sh_in < 0) ? MW'(-e1_sh_in) : MW'(e1_sh_in);
      e1_k_ff  <= (e1_sk_in < 0) ? MW'(-e1_sk_in) : MW'(e1_sk_in);
      e1_hm_ff <= MW'($signed(h_root) - hs_ff[SQ_STEPS-1].geo.d);
      e1_hp_ff <= MW'($signed(h_root) + hs_ff[SQ_STEPS-1].geo.d);
      e1_h_ff  <= h_root;
      e1_tail_ff.xz  <= hs_ff[SQ_STEPS-1].geo.xz;
      e1_tail_ff.yz  <= hs_ff[SQ_STEPS-1].geo.yz;
      e1_tail_ff.ori <= hs_ff[SQ_STEPS-1].ori;
      e1_tail_ff.hz  <= (h_root == '0);

      e2_p0_ff   <= mul_split(e1_g_ff, e1_hm_ff);
      e2_p1_ff   <= mul_split(e1_k_ff, e1_hp_ff);
      e2_p2_ff   <= mul_split(e1_g_ff, e1_hp_ff);
      e2_p3_ff   <= mul_split(e1_k_ff, e1_hm_ff);
      e2_g_ff    <= e1_g_ff;
      e2_k_ff    <= e1_k_ff;
      e2_h_ff    <= e1_h_ff;
      e2_tail_ff <= e1_tail_ff;

      e3_gm_ff   <= mul_join(e2_p0_ff);
      e3_kp_ff   <= mul_join(e2_p1_ff);
      e3_gp_ff   <= mul_join(e2_p2_ff);
      e3_km_ff   <= mul_join(e2_p3_ff);
      e3_g_ff    <= e2_g_ff;
      e3_k_ff    <= e2_k_ff;
      e3_h_ff    <= e2_h_ff;
      e3_tail_ff <= e2_tail_ff;

      e4_nx_ff <= DIV_N'({1'b0, e3_gm_ff} + {1'b0, e3_kp_ff}) << NX_SHIFT;
      e4_ny_ff <= DIV_N'({1'b0, e3_gp_ff} + {1'b0, e3_km_ff}) << NX_SHIFT;
      e4_h_ff  <= e3_h_ff;
      e4_mid_ff.ra0  <= RW'(e3_g_ff) << AX_SHIFT;
      e4_mid_ff.ra1  <= RW'(e3_k_ff) << AX_SHIFT;
      e4_mid_ff.tail <= e3_tail_ff;

      dl_ff[0] <= e4_mid_ff;
      for (int i = 1; i < DIV_Q; i++) begin
         dl_ff[i] <= dl_ff[i-1];
      end
      fs_ff[0] <= dl_ff[DIV_Q-1].tail;
      for (int i = 1; i < SQ_STEPS; i++) begin
         fs_ff[i] <= fs_ff[i-1];
      end
   end

   dcdb_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e4_v_ff),
      .in_num    (e4_nx_ff),
      .in_den    (e4_h_ff),
      .out_valid (qx_v),
      .out_quo   (qx)
   );

   dcdb_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e4_v_ff),
      .in_num    (e4_ny_ff),
      .in_den    (e4_h_ff),
      .out_valid (qy_v),
      .out_quo   (qy)
   );

   dcdb_sqrt u_ext_x_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qx_v && qy_v),
      .in_rad    (RW'(qx)),
      .out_valid (rx_v),
      .out_root  (rx)
   );

   dcdb_sqrt u_ext_y_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qx_v && qy_v),
      .in_rad    (RW'(qy)),
      .out_valid (ry_v),
      .out_root  (ry)
   );

   dcdb_sqrt u_axis0_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qx_v && qy_v),
      .in_rad    (dl_ff[DIV_Q-1].ra0),
      .out_valid (r0_v),
      .out_root  (r0)
   );

   dcdb_sqrt u_axis1_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qx_v && qy_v),
      .in_rad    (dl_ff[DIV_Q-1].ra1),
      .out_valid (r1_v),
      .out_root  (r1)
   );

   // A circle has no spread, and its half-extents are the axes themselves.
   always_comb begin
      f_v    = rx_v && ry_v && r0_v && r1_v;
      f_tail = fs_ff[SQ_STEPS-1];
      f_xm   = f_tail.hz ? r0 : rx;
      f_ym   = f_tail.hz ? r1 : ry;
      f_cx   = -56'(f_tail.xz);
      f_cy   = -56'(f_tail.yz);
      f_xm_w = $signed(56'(f_xm));
      f_ym_w = $signed(56'(f_ym));
   end

   always_ff @(posedge clock) begin
      rsp_center_x_ff    <= sat32(f_cx);
      rsp_center_y_ff    <= sat32(f_cy);
      rsp_axis_first_ff  <= (|r0[MW-1:32]) ? 32'hFFFFFFFF : r0[31:0];
      rsp_axis_second_ff <= (|r1[MW-1:32]) ? 32'hFFFFFFFF : r1[31:0];
      rsp_orientation_ff <= f_tail.ori;
      rsp_box_left_ff    <= sat32(f_cx - f_xm_w);
      rsp_box_top_ff     <= sat32(f_cy - f_ym_w);
      rsp_box_right_ff   <= sat32(f_cx + f_xm_w);
      rsp_box_bottom_ff  <= sat32(f_cy + f_ym_w);
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_center_x    = rsp_center_x_ff;
   assign rsp_center_y    = rsp_center_y_ff;
   assign rsp_axis_first  = rsp_axis_first_ff;
   assign rsp_axis_second = rsp_axis_second_ff;
   assign rsp_orientation = rsp_orientation_ff;
   assign rsp_box_left    = rsp_box_left_ff;
   assign rsp_box_top     = rsp_box_top_ff;
   assign rsp_box_right   = rsp_box_right_ff;
   assign rsp_box_bottom  = rsp_box_bottom_ff;

endmodule

// ===== design/dcdb_checker.sv =====
// Port-level checks on the dual conic decomposition block, bound to its top level.
module dcdb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_strobe,
   input logic signed [dcdb_pkg::OW-1:0]  rsp_orientation,
   input logic signed [31:0]              rsp_box_left,
   input logic signed [31:0]              rsp_box_top,
   input logic signed [31:0]              rsp_box_right,
   input logic signed [31:0]              rsp_box_bottom
);
   import dcdb_pkg::*;

   // A result beat only ever follows a request beat by the fixed pipeline depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result beat without a matching request beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_box_left <= rsp_box_right))
      else $error("box left edge lies right of the right edge");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_box_top <= rsp_box_bottom))
      else $error("box top edge lies below the bottom edge");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_orientation <= OW'(HALF_PI_Q13)
                      && rsp_orientation >= -OW'(HALF_PI_Q13)))
      else $error("orientation outside a half turn");

endmodule

bind dual_conic_decompose_bbox dcdb_checker u_dcdb_checker (.*);
